// ===== rtl/csb_pkg.sv =====
// Package for the comment and string blanker.
// Holds item types, scan state, character codes and status codes.
// No dependencies.
`timescale 1ns / 1ps

package csb_pkg;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef enum logic [0:0] {
      KIND_TEXT = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_LINE   = 2'd1,
      MODE_BLOCK  = 2'd2,
      MODE_QUOTE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_UNTERM_BLOCK  = 2'd1,
      STATUS_UNTERM_QUOTE  = 2'd2
   } status_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] clean_byte;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      mode_type scan_mode;
      logic     quote_is_double;
      logic     escape_pending;
      logic     slash_held;
      logic     star_seen;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      scan_mode:       MODE_NORMAL,
      quote_is_double: 1'b0,
      escape_pending:  1'b0,
      slash_held:      1'b0,
      star_seen:       1'b0
   };

   function automatic rsp_type char_result(input logic [7:0] b);
      rsp_type r;
      r.result_kind = KIND_TEXT;
      r.clean_byte  = b;
      r.status      = STATUS_OK;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic logic [7:0] blank_of(input logic [7:0] b);
      return (b == CH_NL) ? CH_NL : CH_SPACE;
   endfunction

endpackage

// ===== rtl/comment_string_blanker.sv =====
// Top level of the comment and string blanker: input register, scanner, result queue.
// An accepted item waits in the input register until the result queue has room for its results.
// Throughput: one item per cycle while the result queue has room for its results.
// The result queue (two entries) accepts a new item while earlier results wait.
// Reset clears the input valid flag, the scan state and the queue count at once.
// Depends on csb_pkg and csb_scan.
`timescale 1ns / 1ps

module comment_string_blanker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  csb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output csb_pkg::rsp_type rsp_data
);
   import csb_pkg::*;

   logic           in_valid_ff, in_valid_in;
   req_type        in_item_ff;
   scan_state_type state_ff, state_in;
   rsp_type        q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]     count_ff, count_in;

   scan_state_type scan_nxt;
   logic [1:0]     result_count;
   rsp_type        result0, result1;
   logic           pop, advance;
   logic [1:0]     keep_count, free_count;
   rsp_type        keep0;

   csb_scan u_scan (
      .item         (in_item_ff),
      .state_cur    (state_ff),
      .state_nxt    (scan_nxt),
      .result_count (result_count),
      .result0      (result0),
      .result1      (result1)
   );

   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_data   = q0_ff;
   assign pop        = rsp_valid && rsp_ready;
   assign keep_count = count_ff - {1'b0, pop};
   assign free_count = 2'd2 - keep_count;
   assign advance    = in_valid_ff && (result_count <= free_count);
   assign req_ready  = !in_valid_ff || advance;
   assign keep0      = pop ? q1_ff : q0_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      state_in    = state_ff;
      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = scan_nxt;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end

      q0_in    = keep0;
      q1_in    = q1_ff;
      count_in = keep_count;
      if (advance) begin
         count_in = keep_count + result_count;
         case (keep_count)
            2'd0: begin
               q0_in = result0;
               q1_in = result1;
            end
            2'd1: begin
               q1_in = result0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= SCAN_RESET;
         count_ff    <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

endmodule

// ===== rtl/csb_scan.sv =====
// Scanner step for the comment and string blanker.
// Maps one item and the current scan state to up to two results and the next state.
// Depends on csb_pkg.
`timescale 1ns / 1ps

module csb_scan (
   input  csb_pkg::req_type        item,
   input  csb_pkg::scan_state_type state_cur,
   output csb_pkg::scan_state_type state_nxt,
   output logic [1:0]              result_count,
   output csb_pkg::rsp_type        result0,
   output csb_pkg::rsp_type        result1
);
   import csb_pkg::*;

   logic [7:0] b;
   rsp_type    stat_r;

   assign b = item.data_byte;

   always_comb begin
      state_nxt    = state_cur;
      result_count = 2'd0;
      result0      = char_result(CH_SPACE);
      result1      = char_result(CH_SPACE);
      stat_r       = char_result(8'h00);
      stat_r.result_kind = KIND_END;

      if (item.kind == KIND_END) begin
         case (state_cur.scan_mode)
            MODE_BLOCK: stat_r.status = STATUS_UNTERM_BLOCK;
            MODE_QUOTE: stat_r.status = STATUS_UNTERM_QUOTE;
            default:    stat_r.status = STATUS_OK;
         endcase
         if (state_cur.slash_held) begin
            result0      = char_result(CH_SLASH);
            result1      = stat_r;
            result_count = 2'd2;
         end else begin
            result0      = stat_r;
            result_count = 2'd1;
         end
         state_nxt = SCAN_RESET;
      end else begin
         case (state_cur.scan_mode)
            MODE_LINE: begin
               result0      = char_result(blank_of(b));
               result_count = 2'd1;
               if (b == CH_NL) begin
                  state_nxt.scan_mode = MODE_NORMAL;
               end
            end
            MODE_BLOCK: begin
               result0      = char_result(blank_of(b));
               result_count = 2'd1;
               if (state_cur.star_seen && b == CH_SLASH) begin
                  state_nxt.star_seen = 1'b0;
                  state_nxt.scan_mode = MODE_NORMAL;
               end else begin
                  state_nxt.star_seen = (b == CH_STAR);
               end
            end
            MODE_QUOTE: begin
               result0      = char_result(blank_of(b));
               result_count = 2'd1;
               if (state_cur.escape_pending) begin
                  state_nxt.escape_pending = 1'b0;
               end else if (b == CH_BSLASH) begin
                  state_nxt.escape_pending = 1'b1;
               end else if (b == (state_cur.quote_is_double ? CH_DQUOTE : CH_SQUOTE)) begin
                  state_nxt.scan_mode = MODE_NORMAL;
               end
            end
            default: begin
               if (state_cur.slash_held) begin
                  state_nxt.slash_held = 1'b0;
                  if (b inside {CH_SLASH, CH_STAR}) begin
                     result_count = 2'd2;
                     if (b == CH_SLASH) begin
                        state_nxt.scan_mode = MODE_LINE;
                     end else begin
                        state_nxt.scan_mode = MODE_BLOCK;
                        state_nxt.star_seen = 1'b0;
                     end
                  end else begin
                     // held slash goes out, then the byte as plain text, or a blank if it opens a quote
                     result0      = char_result(CH_SLASH);
                     result_count = 2'd2;
                     if (b inside {CH_SQUOTE, CH_DQUOTE}) begin
                        state_nxt.quote_is_double = (b == CH_DQUOTE);
                        state_nxt.escape_pending  = 1'b0;
                        state_nxt.scan_mode       = MODE_QUOTE;
                        result1 = char_result(CH_SPACE);
                     end else begin
                        result1 = char_result(b);
                     end
                  end
               end else begin
                  if (b == CH_SLASH) begin
                     state_nxt.slash_held = 1'b1;
                  end else if (b inside {CH_SQUOTE, CH_DQUOTE}) begin
                     state_nxt.quote_is_double = (b == CH_DQUOTE);
                     state_nxt.escape_pending  = 1'b0;
                     state_nxt.scan_mode       = MODE_QUOTE;
                     result0      = char_result(CH_SPACE);
                     result_count = 2'd1;
                  end else begin
                     result0      = char_result(b);
                     result_count = 2'd1;
                  end
               end
            end
         endcase
      end

      if (result_count == 2'd1) begin
         result0.last = 1'b1;
      end else if (result_count == 2'd2) begin
         result1.last = 1'b1;
      end
   end

endmodule
